/* hw/rtl/nmm_pkg.sv */
// package: shared constants and types for the nearest mode matcher
package nmm_pkg;
    localparam int MODEL_DEPTH_DEF = 256;
    localparam logic [23:0] MAX24 = 24'hFFFFFF;
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_MODE = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [2:0]  degree;
        logic [23:0] period;
        logic [15:0] weight;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [23:0] matched_period;
        logic [2:0]  matched_degree;
        logic [8:0]  matched_index;
        logic        is_last;
        logic [23:0] fit_quality;
        logic        all_distinct;
    } out_item_t;
endpackage

/* hw/rtl/nmm_in_if.sv */
// interface: input item channel
interface nmm_in_if;
    logic valid;
    logic ready;
    nmm_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/nmm_out_if.sv */
// interface: result item channel
interface nmm_out_if;
    logic valid;
    logic ready;
    nmm_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/nearest_mode_match_weighted_rms.sv */
// Nearest mode matcher with weighted rms period fit.
// Channels: in_ch (sink) takes items with opcode clear, append, mode;
// out_ch (source) gives one result item per observed mode.
// Clear and append items are taken in one cycle each, back to back.
// A mode item scans the model table, one entry per cycle through a single
// registered memory read port, then squares the difference and multiplies by
// the weight in 24-by-8-bit partial products. On the last mode with a nonempty
// table and a nonzero weight sum a restoring divider and a bit-pair square root
// follow before the result is written.
// in_ch is not ready while a mode item is worked; a result waits in the output
// register until taken, and a following mode item holds in its last step
// until the register frees, which keeps in_ch not ready meanwhile.
// Reset clears the table count and per-star sums; table contents stay
// undefined and are only read below the count.
module nearest_mode_match_weighted_rms #(
    parameter int MODEL_DEPTH = nmm_pkg::MODEL_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    nmm_in_if.sink    in_ch,
    nmm_out_if.source out_ch
);
    localparam int AW = $clog2(MODEL_DEPTH);
    localparam int CW = $clog2(MODEL_DEPTH + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_LAST  = 9'b000000100,
        S_MUL   = 9'b000001000,
        S_ACC   = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_SQRT  = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_WAIT  = 9'b100000000
    } state_t;

    state_t state_reg;
    nmm_pkg::in_item_t item_reg;
    logic [2:0]  mem_deg [MODEL_DEPTH];
    logic [23:0] mem_per [MODEL_DEPTH];
    logic [2:0]  rd_deg_reg;
    logic [23:0] rd_per_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] scan_reg;
    logic          rd_ok_reg;
    logic [CW-1:0] rd_idx_reg;
    logic          found_reg;
    logic [23:0] best_reg;
    logic [23:0] mper_reg;
    logic [2:0]  mdeg_reg;
    logic [CW-1:0] midx_reg;
    logic [8:0]  prev_reg;
    logic        first_reg;
    logic        dist_reg;
    logic [31:0] wsum_reg;
    logic [63:0] esum_reg;
    logic [63:0] prod_reg;
    logic [2:0]  step_reg;
    logic [47:0] sq_reg;
    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] srem_reg;
    logic [31:0] sres_reg;
    logic [23:0] fq_reg;
    nmm_pkg::out_item_t out_reg;
    logic        ovalid_reg;

    logic [23:0] d_cur;
    logic [23:0] d_match;
    logic [8:0]  midx9;
    logic [32:0] rem_sh;
    logic [7:0]  pp;
    logic [63:0] es_add;
    logic [32:0] ws_add;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = ovalid_reg;
    assign out_ch.data = out_reg;

    assign d_cur = (rd_per_reg > item_reg.period) ? rd_per_reg - item_reg.period
                                                  : item_reg.period - rd_per_reg;
    assign d_match = (mper_reg > item_reg.period) ? mper_reg - item_reg.period
                                                  : item_reg.period - mper_reg;
    assign midx9 = 9'(midx_reg);
    assign rem_sh = {rem_reg[31:0], quo_reg[63]};
    assign pp = item_reg.weight[15:8];
    assign ws_add = {1'b0, wsum_reg} + 33'(item_reg.weight);
    assign es_add = esum_reg + prod_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_ch.valid && in_ch.ready
            && in_ch.data.opcode == nmm_pkg::OP_APPEND && count_reg < CW'(MODEL_DEPTH))
        begin
            mem_deg[count_reg[AW-1:0]] <= in_ch.data.degree;
            mem_per[count_reg[AW-1:0]] <= in_ch.data.period;
        end
        rd_deg_reg <= mem_deg[scan_reg[AW-1:0]];
        rd_per_reg <= mem_per[scan_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            prev_reg <= '0;
            first_reg <= 1'b1;
            dist_reg <= 1'b1;
            wsum_reg <= '0;
            esum_reg <= '0;
            ovalid_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && out_ch.ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        item_reg <= in_ch.data;
                        scan_reg <= '0;
                        rd_ok_reg <= 1'b0;
                        found_reg <= 1'b0;
                        mper_reg <= 24'd256;
                        mdeg_reg <= 3'd1;
                        midx_reg <= '0;
                        best_reg <= '0;
                        case (in_ch.data.opcode)
                            nmm_pkg::OP_CLEAR: count_reg <= '0;
                            nmm_pkg::OP_APPEND:
                                if (count_reg < CW'(MODEL_DEPTH))
                                    count_reg <= count_reg + 1'b1;
                            nmm_pkg::OP_MODE: state_reg <= S_SCAN;
                            default: ;
                        endcase
                    end
                end
                S_SCAN:
                begin
                    rd_ok_reg <= scan_reg < count_reg;
                    rd_idx_reg <= scan_reg + 1'b1;
                    if (scan_reg < count_reg)
                        scan_reg <= scan_reg + 1'b1;
                    if (rd_ok_reg && rd_deg_reg == item_reg.degree
                        && (!found_reg || d_cur < best_reg))
                    begin
                        found_reg <= 1'b1;
                        best_reg <= d_cur;
                        mper_reg <= rd_per_reg;
                        mdeg_reg <= rd_deg_reg;
                        midx_reg <= rd_idx_reg;
                    end
                    if (!rd_ok_reg && scan_reg >= count_reg && scan_reg != 0
                        || (count_reg == 0))
                        state_reg <= S_LAST;
                end
                S_LAST:
                begin
                    if (!first_reg && midx9 == prev_reg)
                        dist_reg <= 1'b0;
                    first_reg <= 1'b0;
                    prev_reg <= midx9;
                    wsum_reg <= ws_add[32] ? 32'hFFFFFFFF : ws_add[31:0];
                    sq_reg <= 48'(d_match) * 48'(d_match);
                    step_reg <= '0;
                    prod_reg <= '0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    // shift-add by weight bytes over the 48-bit square, 24-bit chunks
                    case (step_reg)
                        3'd0: prod_reg <= 64'(32'(sq_reg[23:0]) * 32'(pp));
                        3'd1: prod_reg <= prod_reg
                            + (64'(32'(sq_reg[47:24]) * 32'(pp)) << 24);
                        3'd2: prod_reg <= prod_reg << 8;
                        3'd3: prod_reg <= prod_reg
                            + 64'(32'(sq_reg[23:0]) * 32'(item_reg.weight[7:0]));
                        default: prod_reg <= prod_reg
                            + (64'(32'(sq_reg[47:24]) * 32'(item_reg.weight[7:0])) << 24);
                    endcase
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd4)
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    esum_reg <= (es_add < esum_reg) ? 64'hFFFFFFFFFFFFFFFF : es_add;
                    quo_reg <= (es_add < esum_reg) ? 64'hFFFFFFFFFFFFFFFF : es_add;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                    if (!item_reg.last)
                    begin
                        fq_reg <= '0;
                        state_reg <= S_OUT;
                    end
                    else if (count_reg == 0 || wsum_reg == 0)
                    begin
                        fq_reg <= nmm_pkg::MAX24;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        fq_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (rem_sh >= {1'b0, wsum_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, wsum_reg};
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 7'd63)
                    begin
                        cnt_reg <= '0;
                        srem_reg <= '0;
                        sres_reg <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_SQRT:
                begin
                    // digit-by-digit root: two radicand bits per step
                    logic [65:0] r2;
                    logic [65:0] t;
                    r2 = {srem_reg, quo_reg[63:62]};
                    t = {32'd0, sres_reg, 2'b01};
                    if (r2 >= t)
                    begin
                        srem_reg <= 64'(r2 - t);
                        sres_reg <= {sres_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        srem_reg <= r2[63:0];
                        sres_reg <= {sres_reg[30:0], 1'b0};
                    end
                    quo_reg <= {quo_reg[61:0], 2'b00};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 7'd31)
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    fq_reg <= (sres_reg > 32'(nmm_pkg::MAX24)) ? nmm_pkg::MAX24
                                                              : sres_reg[23:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!ovalid_reg)
                    begin
                        out_reg.matched_period <= mper_reg;
                        out_reg.matched_degree <= mdeg_reg;
                        out_reg.matched_index <= midx9;
                        out_reg.is_last <= item_reg.last;
                        out_reg.fit_quality <= fq_reg;
                        out_reg.all_distinct <= item_reg.last & dist_reg;
                        ovalid_reg <= 1'b1;
                        if (item_reg.last)
                        begin
                            prev_reg <= '0;
                            first_reg <= 1'b1;
                            dist_reg <= 1'b1;
                            wsum_reg <= '0;
                            esum_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ch.ready)
        else $error("input taken while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MODEL_DEPTH))
        else $error("table count beyond depth");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !out_ch.ready |=> ovalid_reg && $stable(out_reg))
        else $error("result lost");
endmodule

/* sim/nearest_mode_match_weighted_rms_test.sv */
// testbench: directed table and random star sequences checked against a mode match predictor
module nearest_mode_match_weighted_rms_test;
    localparam int DEPTH = nmm_pkg::MODEL_DEPTH_DEF;
    localparam logic [1:0] OP_NONE = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    nmm_in_if in_ch();
    nmm_out_if out_ch();

    nearest_mode_match_weighted_rms u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor state
    logic [2:0]  tbl_deg [DEPTH];
    logic [23:0] tbl_per [DEPTH];
    int unsigned tbl_count;
    logic [8:0]  prev_idx;
    bit          first_mode;
    bit          distinct;
    logic [31:0] wsum;
    logic [63:0] esum;

    nmm_pkg::out_item_t match_queue[$];
    int errors = 0;
    int results_seen = 0;
    int items_sent = 0;
    int stars_done = 0;
    bit quiet_sender = 1'b0;
    bit quiet_sink = 1'b0;

    typedef struct {
        nmm_pkg::in_item_t   item;
        bit                  has_expected;
        nmm_pkg::out_item_t  expected;
    } stim_row_t;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = 0;
        b = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void restart_star();
        prev_idx = 0;
        first_mode = 1'b1;
        distinct = 1'b1;
        wsum = 0;
        esum = 0;
    endfunction

    // returns 1 and fills r when the item produces a match result
    function automatic bit predict_match(input nmm_pkg::in_item_t it,
                                         output nmm_pkg::out_item_t r);
        logic [23:0] mper;
        logic [2:0]  mdeg;
        logic [8:0]  midx;
        logic [23:0] best;
        logic [23:0] d;
        bit          found;
        logic [32:0] ws;
        logic [63:0] dd;
        logic [63:0] term;
        logic [64:0] es;
        logic [63:0] root;
        r = '0;
        if (it.opcode == nmm_pkg::OP_CLEAR)
        begin
            tbl_count = 0;
            return 1'b0;
        end
        if (it.opcode == nmm_pkg::OP_APPEND)
        begin
            if (tbl_count < DEPTH)
            begin
                tbl_deg[tbl_count] = it.degree;
                tbl_per[tbl_count] = it.period;
                tbl_count++;
            end
            return 1'b0;
        end
        if (it.opcode != nmm_pkg::OP_MODE)
            return 1'b0;
        mper = 24'd256;
        mdeg = 3'd1;
        midx = 0;
        found = 1'b0;
        best = 0;
        for (int j = 0; j < tbl_count; j++)
        begin
            if (tbl_deg[j] == it.degree)
            begin
                d = tbl_per[j] > it.period ? tbl_per[j] - it.period : it.period - tbl_per[j];
                if (!found || d < best)
                begin
                    found = 1'b1;
                    best = d;
                    mper = tbl_per[j];
                    mdeg = tbl_deg[j];
                    midx = 9'(j + 1);
                end
            end
        end
        if (!first_mode && midx == prev_idx)
            distinct = 1'b0;
        first_mode = 1'b0;
        prev_idx = midx;
        ws = {1'b0, wsum} + it.weight;
        wsum = ws[32] ? 32'hFFFFFFFF : ws[31:0];
        dd = mper > it.period ? mper - it.period : it.period - mper;
        term = dd * dd * 64'(it.weight);
        es = {1'b0, esum} + term;
        esum = es[64] ? 64'hFFFFFFFFFFFFFFFF : es[63:0];
        r.matched_period = mper;
        r.matched_degree = mdeg;
        r.matched_index = midx;
        r.is_last = it.last;
        if (it.last)
        begin
            if (tbl_count == 0 || wsum == 0)
                r.fit_quality = nmm_pkg::MAX24;
            else
            begin
                root = int_sqrt(esum / wsum);
                r.fit_quality = root > nmm_pkg::MAX24 ? nmm_pkg::MAX24 : root[23:0];
            end
            r.all_distinct = distinct;
            restart_star();
        end
        return 1'b1;
    endfunction

    function automatic nmm_pkg::in_item_t mk(input logic [1:0] op, input logic [2:0] dg,
                                             input logic [23:0] per, input logic [15:0] w,
                                             input logic lst);
        nmm_pkg::in_item_t it;
        it.opcode = op;
        it.degree = dg;
        it.period = per;
        it.weight = w;
        it.last = lst;
        return it;
    endfunction

    // valid stays high into the next item unless the sender idles
    task automatic send_item(input nmm_pkg::in_item_t it);
        nmm_pkg::out_item_t r;
        if (!quiet_sender)
            while ($urandom_range(99) < 25)
            begin
                in_ch.valid <= 1'b0;
                @(posedge clk);
            end
        if (predict_match(it, r))
            match_queue.push_back(r);
        in_ch.data <= it;
        in_ch.valid <= 1'b1;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (match_queue.size() != 0)
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        nmm_pkg::out_item_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (match_queue.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
            end
            else
            begin
                exp_r = match_queue.pop_front();
                if (out_ch.data.matched_period !== exp_r.matched_period)
                begin
                    $error("matched_period exp %0d got %0d", exp_r.matched_period,
                           out_ch.data.matched_period);
                    errors++;
                end
                if (out_ch.data.matched_degree !== exp_r.matched_degree)
                begin
                    $error("matched_degree exp %0d got %0d", exp_r.matched_degree,
                           out_ch.data.matched_degree);
                    errors++;
                end
                if (out_ch.data.matched_index !== exp_r.matched_index)
                begin
                    $error("matched_index exp %0d got %0d", exp_r.matched_index,
                           out_ch.data.matched_index);
                    errors++;
                end
                if (out_ch.data.is_last !== exp_r.is_last)
                begin
                    $error("is_last exp %0d got %0d", exp_r.is_last, out_ch.data.is_last);
                    errors++;
                end
                if (out_ch.data.fit_quality !== exp_r.fit_quality)
                begin
                    $error("fit_quality exp %0d got %0d", exp_r.fit_quality,
                           out_ch.data.fit_quality);
                    errors++;
                end
                if (out_ch.data.all_distinct !== exp_r.all_distinct)
                begin
                    $error("all_distinct exp %0d got %0d", exp_r.all_distinct,
                           out_ch.data.all_distinct);
                    errors++;
                end
                if (exp_r.is_last)
                    stars_done++;
            end
        end
    end

    // sink stall
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= quiet_sink || ($urandom_range(99) >= 25);
    end

    initial
    begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        stim_row_t rows[$];
        nmm_pkg::out_item_t r;
        nmm_pkg::in_item_t it;
        int n_tbl;
        int n_modes;
        logic [23:0] base;

        in_ch.valid = 1'b0;
        in_ch.data = '0;
        restart_star();
        tbl_count = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        r = '0; r.matched_period = 24'd256; r.matched_degree = 3'd1;
        r.is_last = 1'b1; r.fit_quality = nmm_pkg::MAX24; r.all_distinct = 1'b1;
        rows.push_back('{mk(nmm_pkg::OP_MODE, 3'd7, nmm_pkg::MAX24, 16'hFFFF, 1'b1),
                         1'b1, r});
        rows.push_back('{mk(OP_NONE, 3'd7, nmm_pkg::MAX24, 16'hFFFF, 1'b1), 1'b0, r});
        rows.push_back('{mk(nmm_pkg::OP_APPEND, 3'd0, 24'd0, 16'hFFFF, 1'b1), 1'b0, r});
        rows.push_back('{mk(nmm_pkg::OP_APPEND, 3'd7, nmm_pkg::MAX24, 16'd0, 1'b0),
                         1'b0, r});
        rows.push_back('{mk(nmm_pkg::OP_APPEND, 3'd2, 24'd1000, 16'd0, 1'b0), 1'b0, r});
        rows.push_back('{mk(nmm_pkg::OP_APPEND, 3'd2, 24'd1200, 16'd0, 1'b0), 1'b0, r});
        rows.push_back('{mk(nmm_pkg::OP_MODE, 3'd2, 24'd1100, 16'h0100, 1'b0), 1'b0, r});
        rows.push_back('{mk(nmm_pkg::OP_MODE, 3'd5, 24'd0, 16'hFFFF, 1'b0), 1'b0, r});
        rows.push_back('{mk(nmm_pkg::OP_MODE, 3'd5, nmm_pkg::MAX24, 16'hFFFF, 1'b0),
                         1'b0, r});
        rows.push_back('{mk(nmm_pkg::OP_MODE, 3'd0, 24'd0, 16'd0, 1'b0), 1'b0, r});
        rows.push_back('{mk(nmm_pkg::OP_MODE, 3'd7, 24'd0, 16'hFFFF, 1'b1), 1'b0, r});
        r.fit_quality = nmm_pkg::MAX24; r.all_distinct = 1'b1;
        r.matched_period = 24'd1000; r.matched_degree = 3'd2; r.matched_index = 9'd3;
        rows.push_back('{mk(nmm_pkg::OP_MODE, 3'd2, 24'd1000, 16'd0, 1'b1), 1'b1, r});
        rows.push_back('{mk(nmm_pkg::OP_CLEAR, 3'd7, nmm_pkg::MAX24, 16'hFFFF, 1'b1),
                         1'b0, r});
        rows.push_back('{mk(nmm_pkg::OP_MODE, 3'd2, 24'd1000, 16'h0100, 1'b0), 1'b0, r});
        rows.push_back('{mk(nmm_pkg::OP_MODE, 3'd2, 24'd1000, 16'h0100, 1'b1), 1'b0, r});

        foreach (rows[k])
        begin
            send_item(rows[k].item);
            if (rows[k].has_expected)
                match_queue[match_queue.size() - 1] = rows[k].expected;
        end
        wait_drained();

        // fill past capacity
        for (int k = 0; k < DEPTH + 4; k++)
            send_item(mk(nmm_pkg::OP_APPEND, 3'($urandom_range(7)), 24'($urandom),
                         16'($urandom), 1'($urandom)));
        quiet_sender = 1'b1;
        quiet_sink = 1'b1;
        for (int k = 0; k < 20; k++)
            send_item(mk(nmm_pkg::OP_MODE, 3'($urandom_range(7)), 24'($urandom),
                         16'($urandom), k == 19));
        quiet_sender = 1'b0;
        quiet_sink = 1'b0;
        wait_drained();

        // random stars
        while (items_sent < 1450)
        begin
            if ($urandom_range(9) < 8)
            begin
                send_item(mk(nmm_pkg::OP_CLEAR, 3'($urandom), 24'($urandom), 16'($urandom),
                             1'($urandom)));
                n_tbl = $urandom_range(9) == 0 ? $urandom_range(40) : $urandom_range(12);
                base = 24'($urandom_range(1, 8) == 1 ? $urandom : $urandom_range(20000));
                for (int k = 0; k < n_tbl; k++)
                    send_item(mk(nmm_pkg::OP_APPEND, 3'($urandom_range(3)),
                                 $urandom_range(3) == 0 ? 24'($urandom) :
                                 base + 24'($urandom_range(4000)),
                                 16'($urandom), 1'($urandom)));
            end
            n_modes = $urandom_range(1, 8);
            for (int k = 0; k < n_modes; k++)
            begin
                it = mk(nmm_pkg::OP_MODE,
                        3'($urandom_range(7) < 6 ? $urandom_range(3) : $urandom),
                        $urandom_range(4) == 0 ? 24'($urandom) :
                        base + 24'($urandom_range(4000)),
                        $urandom_range(9) == 0 ? 16'd0 : 16'($urandom),
                        k == n_modes - 1);
                if ($urandom_range(19) == 0)
                    it.opcode = OP_NONE;
                send_item(it);
            end
            if ($urandom_range(29) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DEPTH + 200) @(posedge clk);
        $display("covered %0d items, %0d results, %0d completed stars", items_sent,
                 results_seen, stars_done);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/nmm_pkg.sv
hw/rtl/nmm_in_if.sv
hw/rtl/nmm_out_if.sv
hw/rtl/nearest_mode_match_weighted_rms.sv
sim/nearest_mode_match_weighted_rms_test.sv
